### src/rss_pkg.sv
// rss_pkg: shared types and constants of the random subset sampler
// no dependencies; used by rss_key_cell and random_subset_sampler
package rss_pkg;

    localparam int CLS_W  = 7;   // class index width, covers a pool of up to 128
    localparam int KEY_W  = 32;  // random word and key width
    localparam int MASK_W = 80;  // chosen-class mask width (low 64 + high 16)
    localparam int LOW_W  = 64;
    localparam int HIGH_W = 16;
    localparam int USED_W = 7;
    localparam int MODE_W = 2;

    localparam logic [MODE_W-1:0] MODE_FY_MOD  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_FY_MUL  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_KEYS    = 2'd2;
    localparam logic [MODE_W-1:0] MODE_SELECT  = 2'd3;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CLS_W-1:0] idx;
    } rss_entry_t;

endpackage

### src/rss_ram.sv
// rss_ram: generic ram, one write port and two registered read ports
// no dependencies
module rss_ram #(
    parameter int WIDTH = 7,
    parameter int DEPTH = 80
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_a,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

### src/rss_key_cell.sv
// rss_key_cell: one slot of the sorted smallest-key chain
// depends on rss_pkg for the entry type
module rss_key_cell (
    input  logic               clk,
    input  logic               ins_en,
    input  logic               shift_en,
    input  logic               occ,
    input  rss_pkg::rss_entry_t new_entry,
    input  rss_pkg::rss_entry_t left_entry,
    input  logic               left_gt,
    input  rss_pkg::rss_entry_t right_entry,
    output rss_pkg::rss_entry_t entry,
    output logic               gt
);
    import rss_pkg::*;

    rss_entry_t entry_reg;

    // strict compare keeps the earlier index ahead on equal keys
    assign gt    = !occ || (entry_reg.key > new_entry.key);
    assign entry = entry_reg;

    always_ff @(posedge clk)
    begin
        if (shift_en)
        begin
            entry_reg <= right_entry;
        end
        else if (ins_en && gt)
        begin
            entry_reg <= left_gt ? left_entry : new_entry;
        end
    end

endmodule

### src/random_subset_sampler.sv
// random_subset_sampler: top level, draws DRAWN_COUNT of POOL_SIZE classes
// depends on rss_pkg, rss_ram and rss_key_cell
//
// Usage:
//   input channel  in_valid / in_stall carries random_word, one per transaction
//   output channel out_valid / out_stall carries mask_low, mask_high, words_used
//   cfg_write with cfg_data selects the mode and restarts the draw
// A draw consumes min(DRAWN_COUNT, POOL_SIZE) words (Fisher-Yates), POOL_SIZE
// words (smallest keys), or until enough are kept or the pool ends (selection).
// Work per word, set by the per-word sequencer:
//   modulo mode       4-bit remainder steps over the word, ram read, swap
//   multiply mode     multiply, ram read, swap
//   smallest keys     one insert into the cell chain, plus a drain of the
//                    chain into the mask at the end
//   selection         multiply and compare
// The done state loads the result once the output register is free.
// in_stall is high while a word is in work or a finished result waits for a
// full output register; a stalled result holds. Reset clears the mode to 0
// and starts an empty draw; the permutation is tracked by valid bits, so no
// clearing pass is needed.
module random_subset_sampler #(
    parameter int POOL_SIZE   = 80,
    parameter int DRAWN_COUNT = 20
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [rss_pkg::MODE_W-1:0] cfg_data,
    input  logic                       in_valid,
    output logic                       in_stall,
    input  logic [rss_pkg::KEY_W-1:0]  random_word,
    output logic                       out_valid,
    input  logic                       out_stall,
    output logic [rss_pkg::LOW_W-1:0]  mask_low,
    output logic [rss_pkg::HIGH_W-1:0] mask_high,
    output logic [rss_pkg::USED_W-1:0] words_used
);
    import rss_pkg::*;

    localparam int STEP_W   = $clog2(POOL_SIZE + 1);
    localparam int ADDR_W   = $clog2(POOL_SIZE);
    localparam int CNT_W    = $clog2(DRAWN_COUNT + 1);
    localparam int PROD_W   = KEY_W + STEP_W;
    localparam int FY_STEPS = (DRAWN_COUNT < POOL_SIZE) ? DRAWN_COUNT : POOL_SIZE;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b0_0000_0001,
        ST_MOD   = 9'b0_0000_0010,
        ST_MUL   = 9'b0_0000_0100,
        ST_RD    = 9'b0_0000_1000,
        ST_SWAP  = 9'b0_0001_0000,
        ST_KEY   = 9'b0_0010_0000,
        ST_SEL   = 9'b0_0100_0000,
        ST_DRAIN = 9'b0_1000_0000,
        ST_DONE  = 9'b1_0000_0000
    } state_t;

    function automatic logic [STEP_W-1:0] mod_step4(input logic [STEP_W-1:0] r,
                                                    input logic [3:0] nib,
                                                    input logic [STEP_W-1:0] d);
        logic [STEP_W:0]   t;
        logic [STEP_W-1:0] acc;
        acc = r;
        for (int i = 0; i < 4; i++)
        begin
            t = {acc, nib[3-i]};
            if (t >= {1'b0, d})
            begin
                t = t - {1'b0, d};
            end
            acc = t[STEP_W-1:0];
        end
        return acc;
    endfunction

    function automatic logic [MASK_W-1:0] mark(input logic [MASK_W-1:0] m,
                                               input logic [CLS_W-1:0] c);
        logic [MASK_W-1:0] res;
        res = m;
        if (32'(c) < MASK_W)
        begin
            res[c] = 1'b1;
        end
        return res;
    endfunction

    state_t              state_reg, state_next;
    logic [MODE_W-1:0]   mode_reg, mode_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [CNT_W-1:0]    chosen_reg, chosen_next;
    logic [CNT_W-1:0]    drain_reg, drain_next;
    logic [2:0]          nib_cnt_reg, nib_cnt_next;
    logic [MASK_W-1:0]   mask_acc_reg, mask_acc_next;
    logic [POOL_SIZE-1:0] pvalid_reg, pvalid_next;
    logic                pvj_reg, pvj_next, pvk_reg, pvk_next;
    logic [KEY_W-1:0]    word_reg, word_next;
    logic [KEY_W-1:0]    key_word_reg;
    logic [STEP_W-1:0]   rem_reg, rem_next;
    logic [STEP_W-1:0]   off_reg, off_next;
    logic                out_valid_reg;
    logic [MASK_W-1:0]   out_mask_reg;
    logic [USED_W-1:0]   out_used_reg;

    logic                load_out, ins_en, shift_en, ram_we;
    logic [STEP_W-1:0]   rest, step_inc, k_pos;
    logic [CNT_W-1:0]    chosen_inc, drain_inc, need;
    logic [PROD_W-1:0]   prod;
    logic [STEP_W-1:0]   prod_hi;
    logic [ADDR_W-1:0]   j_addr, k_addr;
    logic [CLS_W-1:0]    rd_j, rd_k, val_j, val_k;
    logic                sel_hit;

    rss_entry_t          new_entry;
    rss_entry_t          cell_q  [DRAWN_COUNT];
    logic                cell_gt [DRAWN_COUNT];

    assign rest       = STEP_W'(POOL_SIZE) - step_reg;
    assign step_inc   = step_reg + 1'b1;
    assign chosen_inc = chosen_reg + 1'b1;
    assign drain_inc  = drain_reg + 1'b1;
    assign need       = CNT_W'(DRAWN_COUNT) - chosen_reg;
    assign prod       = PROD_W'(word_reg) * PROD_W'(rest);
    assign prod_hi    = prod[PROD_W-1:KEY_W];
    assign sel_hit    = 32'(prod_hi) < 32'(need);
    assign k_pos      = step_reg + off_reg;
    assign j_addr     = ADDR_W'(step_reg);
    assign k_addr     = ADDR_W'(k_pos);
    assign val_j      = pvj_reg ? rd_j : CLS_W'(step_reg);
    assign val_k      = pvk_reg ? rd_k : CLS_W'(k_pos);

    assign new_entry.key = key_word_reg;
    assign new_entry.idx = CLS_W'(step_reg);

    rss_ram #(
        .WIDTH(CLS_W),
        .DEPTH(POOL_SIZE)
    ) u_perm_ram (
        .clk      (clk),
        .wr_en    (ram_we),
        .wr_addr  (k_addr),
        .wr_data  (val_j),
        .rd_addr_a(j_addr),
        .rd_addr_b(k_addr),
        .rd_data_a(rd_j),
        .rd_data_b(rd_k)
    );

    for (genvar p = 0; p < DRAWN_COUNT; p++)
    begin : g_cell
        rss_key_cell u_cell (
            .clk        (clk),
            .ins_en     (ins_en),
            .shift_en   (shift_en),
            .occ        (32'(p) < 32'(chosen_reg)),
            .new_entry  (new_entry),
            .left_entry ((p == 0) ? new_entry : cell_q[(p == 0) ? 0 : p-1]),
            .left_gt    ((p == 0) ? 1'b0 : cell_gt[(p == 0) ? 0 : p-1]),
            .right_entry(cell_q[(p == DRAWN_COUNT-1) ? p : p+1]),
            .entry      (cell_q[p]),
            .gt         (cell_gt[p])
        );
    end

    always_comb
    begin
        state_next    = state_reg;
        mode_next     = mode_reg;
        step_next     = step_reg;
        chosen_next   = chosen_reg;
        drain_next    = drain_reg;
        nib_cnt_next  = nib_cnt_reg;
        mask_acc_next = mask_acc_reg;
        pvalid_next   = pvalid_reg;
        pvj_next      = pvj_reg;
        pvk_next      = pvk_reg;
        word_next     = word_reg;
        rem_next      = rem_reg;
        off_next      = off_reg;
        load_out      = 1'b0;
        ins_en        = 1'b0;
        shift_en      = 1'b0;
        ram_we        = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    word_next    = random_word;
                    rem_next     = '0;
                    nib_cnt_next = '0;
                    case (mode_reg)
                        MODE_FY_MOD: state_next = ST_MOD;
                        MODE_FY_MUL: state_next = ST_MUL;
                        MODE_KEYS:   state_next = ST_KEY;
                        default:     state_next = ST_SEL;
                    endcase
                end
            end
            ST_MOD:
            begin
                rem_next     = mod_step4(rem_reg, word_reg[KEY_W-1 -: 4], rest);
                word_next    = word_reg << 4;
                nib_cnt_next = nib_cnt_reg + 1'b1;
                if (nib_cnt_reg == 3'd7)
                begin
                    off_next   = rem_next;
                    state_next = ST_RD;
                end
            end
            ST_MUL:
            begin
                off_next   = prod_hi;
                state_next = ST_RD;
            end
            ST_RD:
            begin
                pvj_next   = pvalid_reg[j_addr];
                pvk_next   = pvalid_reg[k_addr];
                state_next = ST_SWAP;
            end
            ST_SWAP:
            begin
                // position j is never read again, so only slot k is written back
                ram_we              = 1'b1;
                pvalid_next[k_addr] = 1'b1;
                mask_acc_next       = mark(mask_acc_reg, val_k);
                step_next           = step_inc;
                state_next = (step_inc >= STEP_W'(FY_STEPS)) ? ST_DONE : ST_IDLE;
            end
            ST_KEY:
            begin
                ins_en    = 1'b1;
                step_next = step_inc;
                if (chosen_reg < CNT_W'(DRAWN_COUNT))
                begin
                    chosen_next = chosen_inc;
                end
                drain_next = '0;
                state_next = (step_inc >= STEP_W'(POOL_SIZE)) ? ST_DRAIN : ST_IDLE;
            end
            ST_DRAIN:
            begin
                shift_en   = 1'b1;
                drain_next = drain_inc;
                if (drain_reg < chosen_reg)
                begin
                    mask_acc_next = mark(mask_acc_reg, cell_q[0].idx);
                end
                if (drain_inc >= chosen_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_SEL:
            begin
                step_next = step_inc;
                if (sel_hit)
                begin
                    mask_acc_next = mark(mask_acc_reg, CLS_W'(step_reg));
                    chosen_next   = chosen_inc;
                end
                if ((sel_hit && chosen_inc >= CNT_W'(DRAWN_COUNT))
                    || step_inc >= STEP_W'(POOL_SIZE))
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    load_out      = 1'b1;
                    step_next     = '0;
                    chosen_next   = '0;
                    mask_acc_next = '0;
                    pvalid_next   = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // a mode write restarts the draw
        if (cfg_write)
        begin
            mode_next     = cfg_data;
            step_next     = '0;
            chosen_next   = '0;
            mask_acc_next = '0;
            pvalid_next   = '0;
            state_next    = ST_IDLE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_FY_MOD;
            step_reg      <= '0;
            chosen_reg    <= '0;
            drain_reg     <= '0;
            nib_cnt_reg   <= '0;
            mask_acc_reg  <= '0;
            pvalid_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            mode_reg     <= mode_next;
            step_reg     <= step_next;
            chosen_reg   <= chosen_next;
            drain_reg    <= drain_next;
            nib_cnt_reg  <= nib_cnt_next;
            mask_acc_reg <= mask_acc_next;
            pvalid_reg   <= pvalid_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
        rem_reg  <= rem_next;
        off_reg  <= off_next;
        pvj_reg  <= pvj_next;
        pvk_reg  <= pvk_next;
        if (state_reg == ST_IDLE && in_valid)
        begin
            key_word_reg <= random_word;
        end
        if (load_out)
        begin
            out_mask_reg <= mask_acc_reg;
            out_used_reg <= USED_W'(step_reg);
        end
    end

    assign in_stall   = (state_reg != ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign mask_low   = out_mask_reg[LOW_W-1:0];
    assign mask_high  = out_mask_reg[MASK_W-1:LOW_W];
    assign words_used = out_used_reg;

    a_chosen_bound: assert property (@(posedge clk) disable iff (!rst_n)
        chosen_reg <= CNT_W'(DRAWN_COUNT))
        else $error("chosen count beyond drawn count");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        step_reg <= STEP_W'(POOL_SIZE))
        else $error("step count beyond pool size");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !cfg_write) |=> in_stall)
        else $error("accepted transaction did not start work");

    a_result_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DONE && out_valid && out_stall && !cfg_write)
        |=> (state_reg == ST_DONE && out_valid))
        else $error("finished draw lost while output stalled");

endmodule

### verif/rss_checker.sv
`timescale 1ns / 1ps
// rss_checker: watches the sampler's channels, predicts each draw and checks the results
// depends on rss_pkg; instantiated beside the block by tb_random_subset_sampler
module rss_checker #(
    parameter int POOL_SIZE   = 80,
    parameter int DRAWN_COUNT = 20
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_write,
    input  logic [rss_pkg::MODE_W-1:0] cfg_data,
    input  logic                       in_valid,
    input  logic                       in_stall,
    input  logic [rss_pkg::KEY_W-1:0]  random_word,
    input  logic                       out_valid,
    input  logic                       out_stall,
    input  logic [rss_pkg::LOW_W-1:0]  mask_low,
    input  logic [rss_pkg::HIGH_W-1:0] mask_high,
    input  logic [rss_pkg::USED_W-1:0] words_used,
    output int                         fail_count,
    output int                         draws_pending,
    output int                         draws_checked
);
    import rss_pkg::*;

    localparam int FY_STEPS = (DRAWN_COUNT < POOL_SIZE) ? DRAWN_COUNT : POOL_SIZE;

    typedef struct {
        logic [LOW_W-1:0]  low;
        logic [HIGH_W-1:0] high;
        logic [USED_W-1:0] used;
    } draw_result_t;

    draw_result_t draws_due[$];

    logic [MODE_W-1:0] cur_mode;
    logic [CLS_W-1:0]  order[128];
    int                word_no;
    int                kept;
    logic [KEY_W-1:0]  best_key[32];
    logic [CLS_W-1:0]  best_cls[32];
    logic [MASK_W-1:0] chosen_mask;

    function automatic void start_draw();
        for (int i = 0; i < 128; i++)
            order[i] = CLS_W'(i);
        word_no = 0;
        kept = 0;
        chosen_mask = '0;
    endfunction

    function automatic void mark(int c);
        if (c < MASK_W)
            chosen_mask[c] = 1'b1;
    endfunction

    // sorted insert, an equal key stays ahead of the newcomer
    function automatic void insert_key(int p, logic [KEY_W-1:0] k, int c);
        while (p > 0 && best_key[p-1] > k)
        begin
            best_key[p] = best_key[p-1];
            best_cls[p] = best_cls[p-1];
            p--;
        end
        best_key[p] = k;
        best_cls[p] = CLS_W'(c);
    endfunction

    function automatic void draw_word(logic [KEY_W-1:0] w);
        longint unsigned rest;
        longint unsigned need;
        int              off;
        int              k;
        logic [CLS_W-1:0] t;
        bit              done;
        draw_result_t    r;
        done = 0;
        if (cur_mode == MODE_FY_MOD || cur_mode == MODE_FY_MUL)
        begin
            rest = longint'(POOL_SIZE - word_no);
            if (cur_mode == MODE_FY_MOD)
                off = int'(longint'(w) % rest);
            else
                off = int'((longint'(w) * rest) >> 32);
            k = (word_no + off) & 127;
            t = order[word_no & 127];
            order[word_no & 127] = order[k];
            order[k] = t;
            mark(order[word_no & 127]);
            word_no++;
            done = word_no >= FY_STEPS;
        end
        else if (cur_mode == MODE_KEYS)
        begin
            if (kept < DRAWN_COUNT)
            begin
                insert_key(kept, w, word_no);
                kept++;
            end
            else if (w < best_key[DRAWN_COUNT-1])
                insert_key(DRAWN_COUNT - 1, w, word_no);
            word_no++;
            if (word_no >= POOL_SIZE)
            begin
                for (int q = 0; q < kept && q < 32; q++)
                    mark(best_cls[q]);
                done = 1;
            end
        end
        else
        begin
            need = longint'(DRAWN_COUNT - kept) << 32;
            if (longint'(w) * longint'(POOL_SIZE - word_no) < need)
            begin
                mark(word_no);
                kept++;
            end
            word_no++;
            done = kept >= DRAWN_COUNT || word_no >= POOL_SIZE;
        end
        if (done)
        begin
            r.low  = chosen_mask[LOW_W-1:0];
            r.high = chosen_mask[MASK_W-1:LOW_W];
            r.used = USED_W'(word_no);
            draws_due.push_back(r);
            start_draw();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        draw_result_t e;
        if (!rst_n)
        begin
            cur_mode = MODE_FY_MOD;
            for (int i = 0; i < 32; i++)
            begin
                best_key[i] = '0;
                best_cls[i] = '0;
            end
            start_draw();
            draws_due.delete();
            fail_count = 0;
            draws_checked = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                cur_mode = cfg_data;
                start_draw();
            end
            if (in_valid && !in_stall)
                draw_word(random_word);
            if (out_valid && !out_stall)
            begin
                if (draws_due.size() == 0)
                begin
                    $display("%0t: unexpected result mask %h_%h used %0d", $time,
                             mask_high, mask_low, words_used);
                    fail_count++;
                end
                else
                begin
                    e = draws_due.pop_front();
                    draws_checked++;
                    if (mask_low !== e.low)
                    begin
                        $display("%0t: mask_low expected %h actual %h", $time, e.low, mask_low);
                        fail_count++;
                    end
                    if (mask_high !== e.high)
                    begin
                        $display("%0t: mask_high expected %h actual %h", $time, e.high,
                                 mask_high);
                        fail_count++;
                    end
                    if (words_used !== e.used)
                    begin
                        $display("%0t: words_used expected %0d actual %0d", $time, e.used,
                                 words_used);
                        fail_count++;
                    end
                end
            end
        end
        draws_pending = draws_due.size();
    end

endmodule

### verif/tb_random_subset_sampler.sv
`timescale 1ns / 1ps
// tb_random_subset_sampler: stimulus, idling and verdict for the subset sampler
// depends on rss_pkg, random_subset_sampler and rss_checker
module tb_random_subset_sampler;
    import rss_pkg::*;

    localparam int LIMIT = 600000;

    logic                clk;
    logic                rst_n;
    logic                cfg_write;
    logic [MODE_W-1:0]   cfg_data;
    logic                in_valid;
    logic                in_stall;
    logic [KEY_W-1:0]    random_word;
    logic                out_valid;
    logic                out_stall;
    logic [LOW_W-1:0]    mask_low;
    logic [HIGH_W-1:0]   mask_high;
    logic [USED_W-1:0]   words_used;
    int                  fail_count;
    int                  draws_pending;
    int                  draws_checked;
    int                  words_sent;
    int                  cycle_no = 0;
    bit                  quiet;

    random_subset_sampler u_top (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .random_word(random_word),
        .out_valid(out_valid), .out_stall(out_stall), .mask_low(mask_low),
        .mask_high(mask_high), .words_used(words_used)
    );

    rss_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_write(cfg_write), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .random_word(random_word),
        .out_valid(out_valid), .out_stall(out_stall), .mask_low(mask_low),
        .mask_high(mask_high), .words_used(words_used), .fail_count(fail_count),
        .draws_pending(draws_pending), .draws_checked(draws_checked)
    );

    initial
    begin
        clk = 0;
    end

    always
    begin
        #5 clk = 1;
        #5 clk = 0;
    end

    always @(posedge clk)
    begin
        cycle_no <= cycle_no + 1;
        if (cycle_no > LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_no);
            $display("*** FAILED ***");
            $finish;
        end
    end

    // one transaction on the input channel, then maybe a gap
    task automatic send_word(logic [KEY_W-1:0] w);
        int gap;
        in_valid <= 1'b1;
        random_word <= w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        words_sent++;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 10);
            in_valid <= 1'b0;
            random_word <= $urandom;
            repeat (gap) @(posedge clk);
        end
    endtask

    // drain, let the last word's work finish, then write the mode
    task automatic set_mode(logic [MODE_W-1:0] m);
        in_valid <= 1'b0;
        @(posedge clk);
        while (draws_pending != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_data <= m;
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [KEY_W-1:0] pick_word(int style);
        case (style)
            0: return '0;
            1: return '1;
            2: return KEY_W'($urandom_range(0, 7));          // many equal keys
            3: return 32'hFFFF_FFF0 | KEY_W'($urandom_range(0, 15));
            4: return KEY_W'($urandom) >> $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // receiver: random stall bursts, one long hold-off early on
    initial
    begin
        int n;
        out_stall = 1'b0;
        @(posedge rst_n);
        repeat (1500)
        begin
            @(posedge clk);
            if ($urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 10);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
        out_stall <= 1'b1;
        repeat (600) @(posedge clk);
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                n = $urandom_range(1, 10);
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int phase;
        int style;
        int count;
        logic [MODE_W-1:0] m;
        rst_n = 1'b0;
        cfg_write = 1'b0;
        cfg_data = '0;
        in_valid = 1'b0;
        random_word = '0;
        words_sent = 0;
        quiet = 0;
        phase = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset mode, extreme words, then a partial draw aborted by a mode write
        for (int i = 0; i < 20; i++)
            send_word(i[0] ? '1 : '0);
        for (int i = 0; i < 5; i++)
            send_word($urandom);

        while (words_sent < 1350)
        begin
            m = MODE_W'(phase % 4);
            set_mode(m);
            style = (phase < 12) ? (phase / 4) % 3 : $urandom_range(0, 7);
            if (m == MODE_KEYS)
                count = 80 * $urandom_range(1, 2) + $urandom_range(0, 30);
            else
                count = $urandom_range(40, 140);
            if (words_sent > 1100)
                quiet = 1;
            for (int i = 0; i < count && words_sent < 1350; i++)
                send_word(($urandom_range(0, 19) == 0) ? $urandom : pick_word(style));
            phase++;
        end

        in_valid <= 1'b0;
        @(posedge clk);
        while (draws_pending != 0)
            @(posedge clk);
        repeat (60) @(posedge clk);
        $display("sent %0d random words over %0d mode phases", words_sent, phase + 1);
        $display("checked %0d draws against the predicted masks", draws_checked);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

### sim.f
src/rss_pkg.sv
src/rss_ram.sv
src/rss_key_cell.sv
src/random_subset_sampler.sv
verif/rss_checker.sv
verif/tb_random_subset_sampler.sv
